### hw/rtl/safl_pkg.sv
package safl_pkg;

	// Pool geometry
	localparam int MAX_SLOTS = 1024;
	localparam int SLOT_W    = $clog2(MAX_SLOTS);
	localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

	// Reset value of the capacity register
	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(MAX_SLOTS);

	// Operation codes
	localparam logic FUNC_ALLOC   = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

	// Status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_FULL    = 2'd1;
	localparam logic [1:0] STAT_INVALID = 2'd2;

	// Request item
	typedef struct packed {
		logic              func;
		logic [SLOT_W-1:0] slot;
	} safl_req_t;

	// Result item
	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] slot_res;
		logic [CNT_W-1:0]  used_count;
	} safl_rsp_t;

	// Write request to the free stack
	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		logic [SLOT_W-1:0] data;
	} safl_stack_wr_t;

	// Write request to the live marks
	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		logic              mark;
	} safl_live_wr_t;

endpackage

### hw/rtl/slot_allocator_free_list_core.sv
// Channel   Direction  Handshake         Payload
// in        input      in_valid/in_stall   safl_req_t  (func, slot)
// out       output     out_valid/out_stall safl_rsp_t  (status, slot_res, used_count)
// cfg       input      cfg_valid/cfg_ready capacity, 11 bits
//
// For each item, the accept edge issues the free-stack and live-mark reads,
// and the commit edge applies the update and loads the result.
// The reads of the two memories are registered.
// A result waiting under out_stall holds the commit, and in_stall stays high
// until that result is taken. Reset needs no clearing pass.
module slot_allocator_free_list_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  safl_pkg::safl_req_t      in_data,
	output logic                     out_valid,
	input  logic                     out_stall,
	output safl_pkg::safl_rsp_t      out_data,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [safl_pkg::CNT_W-1:0] cfg_data
);
	import safl_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic              state_q;
	safl_req_t         item_q;
	logic [CNT_W-1:0]  cap_q;
	logic [CNT_W-1:0]  depth_q;
	logic [CNT_W-1:0]  opened_q;
	logic [CNT_W-1:0]  used_q;
	logic              out_valid_q;
	safl_rsp_t         out_q;

	logic              accept;
	logic              commit;
	logic [CNT_W-1:0]  depth_m1;
	logic [SLOT_W-1:0] stack_rd;
	logic              live_rd;
	logic [CNT_W-1:0]  cap_eff;
	logic              from_stack;
	logic              can_open;
	logic              rel_ok;
	logic [SLOT_W-1:0] granted;
	safl_stack_wr_t    stack_wr;
	safl_live_wr_t     live_wr;
	safl_rsp_t         rsp;
	logic [CNT_W-1:0]  depth_nx;
	logic [CNT_W-1:0]  opened_nx;
	logic [CNT_W-1:0]  used_nx;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign commit    = (state_q == ST_EXEC) && (!out_valid_q || !out_stall);
	assign depth_m1  = depth_q - CNT_W'(1);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	safl_free_stack u_stack (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (depth_m1[SLOT_W-1:0]),
		.wr      (stack_wr),
		.rd_data (stack_rd)
	);

	safl_live_marks u_live (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (in_data.slot),
		.wr      (live_wr),
		.rd_data (live_rd)
	);

	// Decide the operation from the registered reads
	always_comb begin
		cap_eff    = (cap_q > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : cap_q;
		from_stack = (depth_q != '0);
		can_open   = (opened_q < cap_eff);
		rel_ok     = (CNT_W'(item_q.slot) < opened_q) && live_rd;
		granted    = from_stack ? stack_rd : opened_q[SLOT_W-1:0];
		depth_nx   = depth_q;
		opened_nx  = opened_q;
		used_nx    = used_q;
		stack_wr   = '{en: 1'b0, addr: depth_q[SLOT_W-1:0], data: item_q.slot};
		live_wr    = '{en: 1'b0, addr: granted, mark: 1'b1};
		rsp        = '{status: STAT_OK, slot_res: item_q.slot, used_count: used_q};
		unique case (item_q.func)
			FUNC_ALLOC: begin
				if (from_stack || can_open) begin
					if (from_stack) begin
						depth_nx = depth_m1;
					end else begin
						opened_nx = opened_q + CNT_W'(1);
					end
					used_nx       = used_q + CNT_W'(1);
					live_wr.en    = commit;
					rsp.slot_res  = granted;
				end else begin
					rsp.status   = STAT_FULL;
					rsp.slot_res = '0;
				end
			end
			FUNC_RELEASE: begin
				if (rel_ok) begin
					live_wr.addr = item_q.slot;
					live_wr.mark = 1'b0;
					live_wr.en   = commit;
					if (used_q != '0) begin
						used_nx = used_q - CNT_W'(1);
					end
					if (depth_q < CNT_W'(MAX_SLOTS)) begin
						stack_wr.en = commit;
						depth_nx    = depth_q + CNT_W'(1);
					end
				end else begin
					rsp.status = STAT_INVALID;
				end
			end
			default: begin
				rsp.status = STAT_INVALID;
			end
		endcase
		rsp.used_count = used_nx;
	end

	// Sequence: accept, then commit when the output register is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cap_q    <= CAP_RESET;
			depth_q  <= '0;
			opened_q <= '0;
			used_q   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (commit) begin
						state_q  <= ST_IDLE;
						depth_q  <= depth_nx;
						opened_q <= opened_nx;
						used_q   <= used_nx;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_data;
		end
	end

	// Output register: load on commit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_q <= rsp;
		end
	end

	// Every opened slot is either live or waiting on the free stack
	a_conserve: assert property (@(posedge clk) disable iff (!arst_n)
		used_q + depth_q == opened_q)
		else $error("live count plus free depth differs from opened count");

	a_opened_max: assert property (@(posedge clk) disable iff (!arst_n)
		opened_q <= CNT_W'(MAX_SLOTS))
		else $error("opened count beyond pool size");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid_q && (state_q == ST_IDLE))
		else $error("committed item did not reach the output register");

	a_full_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		commit && (rsp.status == STAT_FULL) |=> $stable(opened_q) && $stable(used_q))
		else $error("full allocation changed the counters");

endmodule

### hw/rtl/safl_free_stack.sv
module safl_free_stack (
	input  logic                           clk,
	input  logic                           rd_en,
	input  logic [safl_pkg::SLOT_W-1:0]    rd_addr,
	input  safl_pkg::safl_stack_wr_t       wr,
	output logic [safl_pkg::SLOT_W-1:0]    rd_data
);
	import safl_pkg::*;

	logic [SLOT_W-1:0] mem [MAX_SLOTS];

	// Write pushed slot, register the top-of-stack read
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### hw/rtl/safl_live_marks.sv
module safl_live_marks (
	input  logic                           clk,
	input  logic                           rd_en,
	input  logic [safl_pkg::SLOT_W-1:0]    rd_addr,
	input  safl_pkg::safl_live_wr_t        wr,
	output logic                           rd_data
);
	import safl_pkg::*;

	// Marks at or above the opened count are ignored by the caller, so no clear pass
	logic mem [MAX_SLOTS];

	// Update one mark, register the lookup
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.mark;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import safl_pkg::*;

	typedef enum logic {ROW_OP, ROW_CAP} row_kind_t;

	// One line of the directed plan: either an item or a capacity write
	typedef struct packed {
		row_kind_t         kind;
		logic [CNT_W-1:0]  cap;
		logic              func;
		logic [SLOT_W-1:0] slot;
		logic              typed;
		logic [1:0]        st;
		logic [SLOT_W-1:0] res;
		logic [CNT_W-1:0]  used;
	} plan_row_t;

	localparam int PLAN_N = 30;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	safl_req_t           in_data;
	logic                out_valid;
	logic                out_stall;
	safl_rsp_t           out_data;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CNT_W-1:0]    cfg_data;

	// Expectation typed into the plan travels with the item
	logic                req_typed;
	safl_rsp_t           req_typed_rsp;

	// Own copy of the pool
	int                  pool_cap;
	logic [SLOT_W-1:0]   freed [MAX_SLOTS];
	int                  freed_n;
	int                  opened_n;
	bit                  live [MAX_SLOTS];
	int                  live_n;

	safl_rsp_t           pool_rsp_q [$];
	int                  mismatch_n;
	int                  tx_idle_pct;
	int                  rx_idle_pct;
	int                  hold_len;

	plan_row_t plan [PLAN_N] = '{
		'{ROW_OP,  11'd0,    FUNC_RELEASE, 10'd0,    1'b1, STAT_INVALID, 10'd0,    11'd0},
		'{ROW_OP,  11'd0,    FUNC_RELEASE, 10'd1023, 1'b1, STAT_INVALID, 10'd1023, 11'd0},
		'{ROW_OP,  11'd0,    FUNC_ALLOC,   10'd1023, 1'b1, STAT_OK,      10'd0,    11'd1},
		'{ROW_OP,  11'd0,    FUNC_ALLOC,   10'd0,    1'b1, STAT_OK,      10'd1,    11'd2},
		'{ROW_OP,  11'd0,    FUNC_RELEASE, 10'd1,    1'b0, STAT_OK,      10'd0,    11'd0},
		'{ROW_OP,  11'd0,    FUNC_RELEASE, 10'd1,    1'b1, STAT_INVALID, 10'd1,    11'd1},
		'{ROW_OP,  11'd0,    FUNC_ALLOC,   10'd0,    1'b0, STAT_OK,      10'd0,    11'd0},
		'{ROW_OP,  11'd0,    FUNC_RELEASE, 10'd5,    1'b1, STAT_INVALID, 10'd5,    11'd2},
		// lower capacity to what is already open
		'{ROW_CAP, 11'd2,    FUNC_ALLOC,   10'd0,    1'b0, STAT_OK,      10'd0,    11'd0},
		'{ROW_OP,  11'd0,    FUNC_ALLOC,   10'd0,    1'b1, STAT_FULL,    10'd0,    11'd2},
		'{ROW_OP,  11'd0,    FUNC_RELEASE, 10'd0,    1'b0, STAT_OK,      10'd0,    11'd0},
		'{ROW_OP,  11'd0,    FUNC_ALLOC,   10'd0,    1'b0, STAT_OK,      10'd0,    11'd0},
		// zero capacity: only the free stack can serve
		'{ROW_CAP, 11'd0,    FUNC_ALLOC,   10'd0,    1'b0, STAT_OK,      10'd0,    11'd0},
		'{ROW_OP,  11'd0,    FUNC_ALLOC,   10'd0,    1'b1, STAT_FULL,    10'd0,    11'd2},
		'{ROW_OP,  11'd0,    FUNC_RELEASE, 10'd0,    1'b0, STAT_OK,      10'd0,    11'd0},
		'{ROW_OP,  11'd0,    FUNC_ALLOC,   10'd0,    1'b0, STAT_OK,      10'd0,    11'd0},
		'{ROW_OP,  11'd0,    FUNC_RELEASE, 10'd1,    1'b0, STAT_OK,      10'd0,    11'd0},
		'{ROW_OP,  11'd0,    FUNC_RELEASE, 10'd0,    1'b0, STAT_OK,      10'd0,    11'd0},
		'{ROW_OP,  11'd0,    FUNC_ALLOC,   10'd0,    1'b0, STAT_OK,      10'd0,    11'd0},
		'{ROW_OP,  11'd0,    FUNC_ALLOC,   10'd0,    1'b0, STAT_OK,      10'd0,    11'd0},
		// capacity above the pool size saturates
		'{ROW_CAP, 11'd2047, FUNC_ALLOC,   10'd0,    1'b0, STAT_OK,      10'd0,    11'd0},
		'{ROW_OP,  11'd0,    FUNC_ALLOC,   10'd0,    1'b1, STAT_OK,      10'd2,    11'd3},
		'{ROW_OP,  11'd0,    FUNC_ALLOC,   10'd512,  1'b0, STAT_OK,      10'd0,    11'd0},
		'{ROW_OP,  11'd0,    FUNC_RELEASE, 10'd1023, 1'b1, STAT_INVALID, 10'd1023, 11'd4},
		'{ROW_CAP, 11'd1,    FUNC_ALLOC,   10'd0,    1'b0, STAT_OK,      10'd0,    11'd0},
		'{ROW_OP,  11'd0,    FUNC_ALLOC,   10'd0,    1'b1, STAT_FULL,    10'd0,    11'd4},
		'{ROW_OP,  11'd0,    FUNC_RELEASE, 10'd3,    1'b0, STAT_OK,      10'd0,    11'd0},
		'{ROW_OP,  11'd0,    FUNC_ALLOC,   10'd0,    1'b0, STAT_OK,      10'd0,    11'd0},
		'{ROW_CAP, 11'd1024, FUNC_ALLOC,   10'd0,    1'b0, STAT_OK,      10'd0,    11'd0},
		'{ROW_OP,  11'd0,    FUNC_ALLOC,   10'd0,    1'b0, STAT_OK,      10'd0,    11'd0}
	};

	slot_allocator_free_list_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	// Clear the pool copy to its reset state
	function automatic void pool_clear();
		pool_cap = MAX_SLOTS;
		freed_n  = 0;
		opened_n = 0;
		live_n   = 0;
		for (int i = 0; i < MAX_SLOTS; i++) begin
			freed[i] = '0;
			live[i]  = 1'b0;
		end
	endfunction

	// Apply one allocate or release to the pool copy and return its result
	function automatic safl_rsp_t pool_update(input safl_req_t r);
		safl_rsp_t o;
		int        eff;
		eff        = (pool_cap > MAX_SLOTS) ? MAX_SLOTS : pool_cap;
		o.status   = STAT_OK;
		o.slot_res = r.slot;
		if (r.func == FUNC_ALLOC) begin
			if (freed_n > 0) begin
				freed_n--;
				o.slot_res = freed[freed_n];
			end else if (opened_n < eff) begin
				o.slot_res = SLOT_W'(opened_n);
				opened_n++;
			end else begin
				o.status   = STAT_FULL;
				o.slot_res = '0;
			end
			if (o.status == STAT_OK) begin
				live[o.slot_res] = 1'b1;
				live_n++;
			end
		end else if (int'(r.slot) >= opened_n || !live[r.slot]) begin
			o.status = STAT_INVALID;
		end else begin
			live[r.slot] = 1'b0;
			if (live_n > 0)
				live_n--;
			if (freed_n < MAX_SLOTS) begin
				freed[freed_n] = r.slot;
				freed_n++;
			end
		end
		o.used_count = CNT_W'(live_n);
		return o;
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatch_n++;
		end
	endfunction

	// Track accepted items, config writes and results at every edge
	always @(posedge clk) begin
		safl_rsp_t want;
		safl_rsp_t got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = out_data;
				if (pool_rsp_q.size() == 0) begin
					$display("%0t: result with none expected, expected none, actual %p",
						$time, got);
					mismatch_n++;
				end else begin
					want = pool_rsp_q.pop_front();
					check_field("status", int'(want.status), int'(got.status));
					check_field("slot_res", int'(want.slot_res), int'(got.slot_res));
					check_field("used_count", int'(want.used_count),
						int'(got.used_count));
				end
			end
			if (in_valid && !in_stall) begin
				want = pool_update(in_data);
				pool_rsp_q.insert(pool_rsp_q.size(), req_typed ? req_typed_rsp : want);
			end
			if (cfg_valid && cfg_ready)
				pool_cap = int'(cfg_data);
		end
	end

	// Receiver: random stalls, or a long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				out_stall <= 1'b1;
				hold_len--;
			end else begin
				out_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	// Offer one item, idling first at random, and hold it until accepted
	task automatic send_req(input safl_req_t r, input logic typed, input safl_rsp_t rsp);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		in_data       <= r;
		req_typed     <= typed;
		req_typed_rsp <= rsp;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid and wait until every expected result is back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pool_rsp_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CNT_W-1:0] cap);
		cfg_valid <= 1'b1;
		cfg_data  <= cap;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Random traffic: releases mostly target opened slots, the rest any slot
	task automatic run_traffic(input int n, input int alloc_pct, input bit pause_mid,
			input bit hold_mid);
		safl_req_t r;
		for (int i = 0; i < n; i++) begin
			if (i == n / 2 && pause_mid)
				wait_drained();
			if (i == n / 3 && hold_mid)
				hold_len = 120;
			r.func = ($urandom_range(99) < alloc_pct) ? FUNC_ALLOC : FUNC_RELEASE;
			if (r.func == FUNC_RELEASE && opened_n > 0 && $urandom_range(99) < 75)
				r.slot = SLOT_W'($urandom_range(opened_n - 1));
			else
				r.slot = SLOT_W'($urandom_range(MAX_SLOTS - 1));
			send_req(r, 1'b0, '0);
		end
		wait_drained();
	endtask

	initial begin
		safl_req_t r;
		safl_rsp_t rsp;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		req_typed     = 1'b0;
		req_typed_rsp = '0;
		mismatch_n    = 0;
		hold_len      = 0;
		tx_idle_pct   = 23;
		rx_idle_pct   = 86;
		pool_clear();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed plan
		for (int i = 0; i < PLAN_N; i++) begin
			if (plan[i].kind == ROW_CAP) begin
				wait_drained();
				write_capacity(plan[i].cap);
			end else begin
				r.func         = plan[i].func;
				r.slot         = plan[i].slot;
				rsp.status     = plan[i].st;
				rsp.slot_res   = plan[i].res;
				rsp.used_count = plan[i].used;
				send_req(r, plan[i].typed, rsp);
			end
		end
		wait_drained();

		// Slow receiver, small pool that fills up
		write_capacity(CNT_W'(40));
		run_traffic(420, 60, 1'b0, 1'b0);

		// Slow sender, full pool, pause mid-way until drained
		tx_idle_pct = 86;
		rx_idle_pct = 23;
		write_capacity(CNT_W'(MAX_SLOTS));
		run_traffic(400, 75, 1'b1, 1'b0);

		// No idling, allocation heavy, long receiver hold-off
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_capacity(CNT_W'(700));
		run_traffic(430, 85, 1'b0, 1'b1);

		repeat (8) @(posedge clk);
		if (mismatch_n == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
